// File: rtl/core/polyline_map_stream_parser_unit_macros.svh
// Assertion macros for the map stream parser.
`ifndef POLYLINE_MAP_STREAM_PARSER_UNIT_MACROS_SVH
`define POLYLINE_MAP_STREAM_PARSER_UNIT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define PMSP_ASSERT_IMPL(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define PMSP_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/core/pmsp_pkg.sv
package pmsp_pkg;

   typedef enum logic [3:0] {
      PH_MAGIC  = 4'd0,
      PH_HEAD   = 4'd1,
      PH_BOUNDS = 4'd2,
      PH_LCOUNT = 4'd3,
      PH_LHEAD  = 4'd4,
      PH_PCOUNT = 4'd5,
      PH_PX     = 4'd6,
      PH_PY     = 4'd7,
      PH_DONE   = 4'd8,
      PH_FAIL   = 4'd9
   } phase_type;

   localparam logic [2:0] KIND_LAYER = 3'd4;
   localparam logic [2:0] KIND_POINT = 3'd5;
   localparam logic [2:0] KIND_PEND  = 3'd6;
   localparam logic [2:0] KIND_FINAL = 3'd7;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
   localparam logic [1:0] ST_BAD_VER   = 2'd2;
   localparam logic [1:0] ST_TRUNC     = 2'd3;

   localparam logic [7:0] VERSION_ONE = 8'd1;
   localparam logic [15:0] BOX_LO_INIT = 16'hFFFF;

   // One result event.
   typedef struct packed {
      logic [2:0]  event_kind;
      logic        last_of_run;
      logic [7:0]  layer_id;
      logic [63:0] raw_value;
      logic [15:0] point_x;
      logic [15:0] point_y;
      logic [15:0] box_lo_x;
      logic [15:0] box_lo_y;
      logic [15:0] box_hi_x;
      logic [15:0] box_hi_y;
      logic [15:0] point_total;
      logic [1:0]  code;
   } event_type;

   // Up to three events caused by one byte.
   typedef struct packed {
      logic [1:0] count;
      event_type  ev0;
      event_type  ev1;
      event_type  ev2;
   } group_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0: b = 8'h52;
         2'd1: b = 8'h4D;
         2'd2: b = 8'h41;
         default: b = 8'h50;
      endcase
      return b;
   endfunction

   function automatic logic [2:0] field_last(input phase_type ph);
      logic [2:0] l;
      case (ph)
         PH_MAGIC, PH_HEAD: l = 3'd3;
         PH_BOUNDS, PH_LHEAD: l = 3'd7;
         default: l = 3'd1;
      endcase
      return l;
   endfunction

endpackage

// File: rtl/core/pmsp_front.sv
module pmsp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [7:0]          req_in_byte,
   input  logic                req_last_byte,
   output logic                req_stall,
   output logic                grp_valid,
   output pmsp_pkg::group_type grp_data,
   input  logic                grp_full
);
   import pmsp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  idx_ff, idx_in;
   logic [63:0] acc_ff, acc_in;
   logic [1:0]  slot_ff, slot_in;
   logic [15:0] layers_ff, layers_in;
   logic [31:0] polys_ff, polys_in;
   logic [15:0] pleft_ff, pleft_in;
   logic [15:0] pseen_ff, pseen_in;
   logic [7:0]  layer_ff, layer_in;
   logic [15:0] hx_ff, hx_in;
   logic [15:0] bx0_ff, bx1_ff, bx2_ff, bx3_ff, bx0_in, bx1_in, bx2_in, bx3_in;
   logic [1:0]  fail_ff, fail_in;

   logic        take;
   event_type   evs [3];
   logic [1:0]  n;
   logic [63:0] v;
   logic [15:0] y;
   logic [1:0]  st;

   assign req_stall = grp_full;
   assign take = req_valid && !grp_full;

   always_comb begin
      event_type e;
      phase_type ph_end;
      phase_in = phase_ff; idx_in = idx_ff; acc_in = acc_ff; slot_in = slot_ff;
      layers_in = layers_ff; polys_in = polys_ff; pleft_in = pleft_ff;
      pseen_in = pseen_ff; layer_in = layer_ff; hx_in = hx_ff;
      bx0_in = bx0_ff; bx1_in = bx1_ff; bx2_in = bx2_ff; bx3_in = bx3_ff;
      fail_in = fail_ff;
      n = 2'd0; st = ST_OK; y = 16'd0; v = 64'd0; ph_end = PH_DONE;
      e = '0;
      evs[0] = '0; evs[1] = '0; evs[2] = '0;
      if (phase_ff != PH_DONE && phase_ff != PH_FAIL) begin
         // accumulate little-endian field
         v = (idx_ff == 3'd0) ? {56'd0, req_in_byte}
             : (acc_ff | ({56'd0, req_in_byte} << {idx_ff, 3'b000}));
         acc_in = v;
         y = v[15:0];
         if (phase_ff == PH_MAGIC && req_in_byte != magic_byte(idx_ff[1:0])) begin
            fail_in = ST_BAD_MAGIC; phase_in = PH_FAIL; idx_in = 3'd0;
         end else if (phase_ff == PH_HEAD && idx_ff == 3'd0 &&
                      req_in_byte != VERSION_ONE) begin
            fail_in = ST_BAD_VER; phase_in = PH_FAIL; idx_in = 3'd0;
         end else begin
            if (phase_ff == PH_LHEAD && idx_ff == 3'd0) layer_in = req_in_byte;
            if (idx_ff != field_last(phase_ff)) begin
               idx_in = idx_ff + 3'd1;
            end else begin
               idx_in = 3'd0;
               e.layer_id = layer_in;
               case (phase_ff)
                  PH_MAGIC: phase_in = PH_HEAD;
                  PH_HEAD: begin
                     phase_in = PH_BOUNDS; slot_in = 2'd0;
                  end
                  PH_BOUNDS: begin
                     e.event_kind = {1'b0, slot_ff}; e.raw_value = v;
                     evs[0] = e; n = 2'd1;
                     slot_in = slot_ff + 2'd1;
                     if (slot_ff == 2'd3) phase_in = PH_LCOUNT;
                  end
                  PH_LCOUNT: begin
                     layers_in = v[15:0];
                     phase_in = (v[15:0] == 16'd0) ? PH_DONE : PH_LHEAD;
                  end
                  PH_LHEAD: begin
                     polys_in = v[63:32];
                     e.event_kind = KIND_LAYER; e.raw_value = {32'd0, v[63:32]};
                     evs[0] = e; n = 2'd1;
                     if (v[63:32] == 32'd0) begin
                        layers_in = layers_ff - 16'd1;
                        phase_in = (layers_ff == 16'd1) ? PH_DONE : PH_LHEAD;
                     end else begin
                        phase_in = PH_PCOUNT;
                     end
                  end
                  PH_PX: begin
                     hx_in = y; phase_in = PH_PY;
                  end
                  PH_PCOUNT, PH_PY: begin
                     if (phase_ff == PH_PCOUNT) begin
                        pleft_in = y; pseen_in = 16'd0;
                        bx0_in = BOX_LO_INIT; bx1_in = BOX_LO_INIT;
                        bx2_in = 16'd0; bx3_in = 16'd0;
                     end else begin
                        e.event_kind = KIND_POINT; e.point_x = hx_ff; e.point_y = y;
                        evs[0] = e; n = 2'd1;
                        if (hx_ff < bx0_ff) bx0_in = hx_ff;
                        if (y < bx1_ff) bx1_in = y;
                        if (hx_ff > bx2_ff) bx2_in = hx_ff;
                        if (y > bx3_ff) bx3_in = y;
                        pseen_in = pseen_ff + 16'd1;
                        pleft_in = pleft_ff - 16'd1;
                     end
                     if (pleft_in == 16'd0) begin
                        // close the polyline
                        e = '0;
                        e.layer_id = layer_in; e.event_kind = KIND_PEND;
                        e.box_lo_x = bx0_in; e.box_lo_y = bx1_in;
                        e.box_hi_x = bx2_in; e.box_hi_y = bx3_in;
                        e.point_total = pseen_in;
                        e.code = {1'b0, pseen_in >= 16'd2};
                        evs[n] = e; n = n + 2'd1;
                        polys_in = polys_ff - 32'd1;
                        if (polys_ff == 32'd1) begin
                           layers_in = layers_ff - 16'd1;
                           ph_end = (layers_ff == 16'd1) ? PH_DONE : PH_LHEAD;
                           phase_in = ph_end;
                        end else begin
                           phase_in = PH_PCOUNT;
                        end
                     end else begin
                        phase_in = PH_PX;
                     end
                  end
                  default: phase_in = phase_ff;
               endcase
            end
         end
      end
      if (req_last_byte) begin
         // final status, then return to reset state
         if (fail_in != ST_OK) st = fail_in;
         else if (phase_in == PH_DONE) st = ST_OK;
         else if (phase_in == PH_MAGIC) st = ST_BAD_MAGIC;
         else st = ST_TRUNC;
         e = '0;
         e.event_kind = KIND_FINAL; e.layer_id = layer_in; e.code = st;
         evs[n] = e; n = n + 2'd1;
         phase_in = PH_MAGIC; idx_in = 3'd0; acc_in = 64'd0; slot_in = 2'd0;
         layers_in = 16'd0; polys_in = 32'd0; pleft_in = 16'd0; pseen_in = 16'd0;
         layer_in = 8'd0; hx_in = 16'd0; fail_in = ST_OK;
         bx0_in = BOX_LO_INIT; bx1_in = BOX_LO_INIT; bx2_in = 16'd0; bx3_in = 16'd0;
      end
      if (n != 2'd0) evs[n - 2'd1].last_of_run = 1'b1;
   end

   assign grp_valid = take && (n != 2'd0);
   assign grp_data = '{count: n, ev0: evs[0], ev1: evs[1], ev2: evs[2]};

   // advance parse state on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAGIC; idx_ff <= 3'd0; acc_ff <= 64'd0; slot_ff <= 2'd0;
         layers_ff <= 16'd0; polys_ff <= 32'd0; pleft_ff <= 16'd0;
         pseen_ff <= 16'd0; layer_ff <= 8'd0; hx_ff <= 16'd0; fail_ff <= ST_OK;
         bx0_ff <= BOX_LO_INIT; bx1_ff <= BOX_LO_INIT; bx2_ff <= 16'd0; bx3_ff <= 16'd0;
      end else if (take) begin
         phase_ff <= phase_in; idx_ff <= idx_in; acc_ff <= acc_in; slot_ff <= slot_in;
         layers_ff <= layers_in; polys_ff <= polys_in; pleft_ff <= pleft_in;
         pseen_ff <= pseen_in; layer_ff <= layer_in; hx_ff <= hx_in; fail_ff <= fail_in;
         bx0_ff <= bx0_in; bx1_ff <= bx1_in; bx2_ff <= bx2_in; bx3_ff <= bx3_in;
      end
   end
endmodule

// File: rtl/core/pmsp_back.sv
module pmsp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                grp_valid,
   input  pmsp_pkg::group_type grp_data,
   output logic                grp_full,
   output logic                rsp_valid,
   output pmsp_pkg::event_type rsp_event,
   input  logic                rsp_stall
);
   import pmsp_pkg::*;

   localparam int Depth = 4;

   group_type  q_mem [Depth];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [1:0] sub_ff, sub_in;
   group_type  head;
   logic       pop, fire;

   assign head = q_mem[rd_ff];
   assign grp_full = (cnt_ff == 3'd4);
   assign rsp_valid = (cnt_ff != 3'd0);
   assign fire = rsp_valid && !rsp_stall;
   assign pop = fire && (sub_ff == head.count - 2'd1);

   always_comb begin
      case (sub_ff)
         2'd0: rsp_event = head.ev0;
         2'd1: rsp_event = head.ev1;
         default: rsp_event = head.ev2;
      endcase
   end

   // queue pointers and event index within the head group
   always_comb begin
      wr_in = grp_valid ? wr_ff + 2'd1 : wr_ff;
      rd_in = pop ? rd_ff + 2'd1 : rd_ff;
      cnt_in = cnt_ff + {2'd0, grp_valid} - {2'd0, pop};
      sub_in = pop ? 2'd0 : (fire ? sub_ff + 2'd1 : sub_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 2'd0; rd_ff <= 2'd0; cnt_ff <= 3'd0; sub_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in; sub_ff <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (grp_valid) q_mem[wr_ff] <= grp_data;
   end
endmodule

// File: rtl/core/polyline_map_stream_parser_unit.sv
// Map stream parser: one byte accepted per cycle while the result queue has
// room; each byte may cause up to three results (bound, layer header, point,
// polyline end, final status), which leave one per cycle while rsp_stall is low, from
// a four-group queue, so sustained rate is one byte per cycle except when a byte yields
// several results, in which case output drain of one result per cycle sets the pace.
`include "polyline_map_stream_parser_unit_macros.svh"

module polyline_map_stream_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_kind,
   output logic        rsp_last_of_run,
   output logic [7:0]  rsp_layer_id,
   output logic [63:0] rsp_raw_value,
   output logic [15:0] rsp_point_x,
   output logic [15:0] rsp_point_y,
   output logic [15:0] rsp_box_lo_x,
   output logic [15:0] rsp_box_lo_y,
   output logic [15:0] rsp_box_hi_x,
   output logic [15:0] rsp_box_hi_y,
   output logic [15:0] rsp_point_total,
   output logic [1:0]  rsp_code
);
   import pmsp_pkg::*;

   logic      grp_valid, grp_full;
   group_type grp_data;
   event_type ev;

   pmsp_front u_front (
      .clock, .reset, .req_valid, .req_in_byte, .req_last_byte, .req_stall,
      .grp_valid, .grp_data, .grp_full
   );

   pmsp_back u_back (
      .clock, .reset, .grp_valid, .grp_data, .grp_full,
      .rsp_valid, .rsp_event(ev), .rsp_stall
   );

   assign rsp_event_kind = ev.event_kind;
   assign rsp_last_of_run = ev.last_of_run;
   assign rsp_layer_id = ev.layer_id;
   assign rsp_raw_value = ev.raw_value;
   assign rsp_point_x = ev.point_x;
   assign rsp_point_y = ev.point_y;
   assign rsp_box_lo_x = ev.box_lo_x;
   assign rsp_box_lo_y = ev.box_lo_y;
   assign rsp_box_hi_x = ev.box_hi_x;
   assign rsp_box_hi_y = ev.box_hi_y;
   assign rsp_point_total = ev.point_total;
   assign rsp_code = ev.code;

   `PMSP_ASSERT_IMPL(a_group_nonempty, clock, reset, grp_valid, grp_data.count != 2'd0)
   `PMSP_ASSERT_IMPL(a_stall_no_group, clock, reset, req_stall, !grp_valid)
   `PMSP_ASSERT_NEXT(a_final_ends_run, clock, reset,
      rsp_valid && rsp_event_kind == KIND_FINAL, $past(rsp_last_of_run))
endmodule

// File: tb/sv/tb_polyline_map_stream_parser_unit.sv
`timescale 1ns / 100ps

module tb_polyline_map_stream_parser_unit;
   import pmsp_pkg::*;

   localparam logic [2:0] KIND_MIN_LAT = 3'd0;
   localparam int         CYCLE_LIMIT  = 400000;

   typedef struct packed {
      logic [7:0] data;
      logic       fin;
   } byte_item_t;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_event_kind;
   logic        rsp_last_of_run;
   logic [7:0]  rsp_layer_id;
   logic [63:0] rsp_raw_value;
   logic [15:0] rsp_point_x;
   logic [15:0] rsp_point_y;
   logic [15:0] rsp_box_lo_x;
   logic [15:0] rsp_box_lo_y;
   logic [15:0] rsp_box_hi_x;
   logic [15:0] rsp_box_hi_y;
   logic [15:0] rsp_point_total;
   logic [1:0]  rsp_code;

   polyline_map_stream_parser_unit i_dut (.*);

   byte_item_t pending_bytes[$];
   event_type  expected_events[$];
   int         send_idle_pct;
   int         recv_idle_pct;
   int         error_count;
   int         cycle_count;

   // Parser shadow state
   phase_type   sh_phase;
   logic [2:0]  sh_idx;
   logic [63:0] sh_accum;
   logic [2:0]  sh_slot;
   logic [15:0] sh_layers;
   logic [31:0] sh_polys;
   logic [15:0] sh_points;
   logic [15:0] sh_seen;
   logic [7:0]  sh_layer;
   logic [15:0] sh_x;
   logic [15:0] sh_box[4];
   logic [1:0]  sh_fail;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   function automatic logic [7:0] header_byte(input logic [1:0] i);
      case (i)
         2'd0: return 8'h52;
         2'd1: return 8'h4D;
         2'd2: return 8'h41;
         default: return 8'h50;
      endcase
   endfunction

   task automatic parse_reset();
      sh_phase = PH_MAGIC; sh_idx = 0; sh_accum = 0; sh_slot = 0;
      sh_layers = 0; sh_polys = 0; sh_points = 0; sh_seen = 0;
      sh_layer = 0; sh_x = 0; sh_fail = ST_OK;
      sh_box[0] = BOX_LO_INIT; sh_box[1] = BOX_LO_INIT; sh_box[2] = 0; sh_box[3] = 0;
   endtask

   function automatic event_type blank_event(input logic [2:0] kind);
      event_type e;
      e = '0;
      e.event_kind = kind;
      e.layer_id = sh_layer;
      return e;
   endfunction

   task automatic close_layer();
      sh_layers = sh_layers - 16'd1;
      sh_phase = (sh_layers == 0) ? PH_DONE : PH_LHEAD;
   endtask

   task automatic close_polyline(inout event_type evs[$]);
      event_type e;
      e = blank_event(KIND_PEND);
      e.box_lo_x = sh_box[0]; e.box_lo_y = sh_box[1];
      e.box_hi_x = sh_box[2]; e.box_hi_y = sh_box[3];
      e.point_total = sh_seen;
      e.code = (sh_seen >= 2) ? 2'd1 : 2'd0;
      evs = {evs, e};
      sh_polys = sh_polys - 32'd1;
      if (sh_polys == 0) close_layer();
      else sh_phase = PH_PCOUNT;
   endtask

   // Advance the shadow parser by one byte and queue the events it causes
   task automatic parse_byte(input logic [7:0] b, input logic fin);
      event_type   evs[$];
      event_type   e;
      logic [2:0]  flen;
      logic [15:0] y;
      evs = {};
      if (sh_phase < PH_DONE) begin
         case (sh_phase)
            PH_MAGIC, PH_HEAD: flen = 3'd3;
            PH_BOUNDS, PH_LHEAD: flen = 3'd7;
            default: flen = 3'd1;
         endcase
         if (sh_idx == 0) sh_accum = {56'd0, b};
         else sh_accum = sh_accum | ({56'd0, b} << (8 * sh_idx));
         if (sh_phase == PH_MAGIC && b != header_byte(sh_idx[1:0])) begin
            sh_fail = ST_BAD_MAGIC; sh_phase = PH_FAIL; sh_idx = 0;
         end else if (sh_phase == PH_HEAD && sh_idx == 0 && b != VERSION_ONE) begin
            sh_fail = ST_BAD_VER; sh_phase = PH_FAIL; sh_idx = 0;
         end else begin
            if (sh_phase == PH_LHEAD && sh_idx == 0) sh_layer = b;
            if (sh_idx < flen) begin
               sh_idx = sh_idx + 3'd1;
            end else begin
               sh_idx = 0;
               case (sh_phase)
                  PH_MAGIC: sh_phase = PH_HEAD;
                  PH_HEAD: begin
                     sh_phase = PH_BOUNDS; sh_slot = 0;
                  end
                  PH_BOUNDS: begin
                     e = blank_event(KIND_MIN_LAT + sh_slot);
                     e.raw_value = sh_accum;
                     evs = {evs, e};
                     sh_slot = sh_slot + 3'd1;
                     if (sh_slot >= 4) begin
                        sh_slot = 0; sh_phase = PH_LCOUNT;
                     end
                  end
                  PH_LCOUNT: begin
                     sh_layers = sh_accum[15:0];
                     sh_phase = (sh_layers == 0) ? PH_DONE : PH_LHEAD;
                  end
                  PH_LHEAD: begin
                     sh_polys = sh_accum[63:32];
                     e = blank_event(KIND_LAYER);
                     e.raw_value = {32'd0, sh_polys};
                     evs = {evs, e};
                     if (sh_polys == 0) close_layer();
                     else sh_phase = PH_PCOUNT;
                  end
                  PH_PCOUNT: begin
                     sh_points = sh_accum[15:0];
                     sh_seen = 0;
                     sh_box[0] = BOX_LO_INIT; sh_box[1] = BOX_LO_INIT;
                     sh_box[2] = 0; sh_box[3] = 0;
                     if (sh_points == 0) close_polyline(evs);
                     else sh_phase = PH_PX;
                  end
                  PH_PX: begin
                     sh_x = sh_accum[15:0]; sh_phase = PH_PY;
                  end
                  default: begin
                     y = sh_accum[15:0];
                     e = blank_event(KIND_POINT);
                     e.point_x = sh_x; e.point_y = y;
                     evs = {evs, e};
                     if (sh_x < sh_box[0]) sh_box[0] = sh_x;
                     if (y < sh_box[1]) sh_box[1] = y;
                     if (sh_x > sh_box[2]) sh_box[2] = sh_x;
                     if (y > sh_box[3]) sh_box[3] = y;
                     sh_seen = sh_seen + 16'd1;
                     sh_points = sh_points - 16'd1;
                     if (sh_points == 0) close_polyline(evs);
                     else sh_phase = PH_PX;
                  end
               endcase
            end
         end
      end
      if (fin) begin
         e = blank_event(KIND_FINAL);
         if (sh_fail != ST_OK) e.code = sh_fail;
         else if (sh_phase == PH_DONE) e.code = ST_OK;
         else if (sh_phase == PH_MAGIC) e.code = ST_BAD_MAGIC;
         else e.code = ST_TRUNC;
         evs = {evs, e};
         parse_reset();
      end
      if (evs.size() > 0) evs[evs.size() - 1].last_of_run = 1'b1;
      foreach (evs[i]) expected_events = {expected_events, evs[i]};
   endtask

   // File building helpers
   byte_item_t file_bytes[$];

   task automatic put_bytes(input logic [63:0] v, input int n);
      byte_item_t it;
      for (int i = 0; i < n; i++) begin
         it.data = v[8*i +: 8]; it.fin = 1'b0;
         file_bytes = {file_bytes, it};
      end
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(0, 4))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Build a well-formed file with small random structure
   task automatic build_file(input int max_layers, input int max_polys, input int max_pts);
      int nl, np, nk;
      file_bytes = {};
      put_bytes(64'h5041_4D52, 4);
      put_bytes({40'd0, 16'($urandom_range(0, 65535)), 8'h01}, 4);
      for (int i = 0; i < 4; i++) put_bytes(rand64(), 8);
      nl = $urandom_range(0, max_layers);
      put_bytes(64'(nl), 2);
      for (int l = 0; l < nl; l++) begin
         np = $urandom_range(0, max_polys);
         put_bytes({np[31:0], 16'($urandom_range(0, 65535)), 8'h00,
                    8'($urandom_range(0, 255))}, 8);
         for (int p = 0; p < np; p++) begin
            nk = $urandom_range(0, max_pts);
            put_bytes(64'(nk), 2);
            for (int k = 0; k < nk; k++) begin
               put_bytes({48'd0, rand_coord()}, 2);
               put_bytes({48'd0, rand_coord()}, 2);
            end
         end
      end
   endtask

   // Mark the final byte and queue the file
   task automatic queue_file();
      if (file_bytes.size() == 0) return;
      file_bytes[file_bytes.size() - 1].fin = 1'b1;
      foreach (file_bytes[i]) pending_bytes = {pending_bytes, file_bytes[i]};
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() > 0 || expected_events.size() > 0) @(posedge clock);
   endtask

   // Driver: present the next byte, hold it while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            parse_byte(req_in_byte, req_last_byte);
            void'(pending_bytes.pop_front());
         end
         if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid     <= 1'b1;
            req_in_byte   <= pending_bytes[0].data;
            req_last_byte <= pending_bytes[0].fin;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      event_type got, want;
      cycle_count <= cycle_count + 1;
      if (!reset) rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_event_kind, rsp_last_of_run, rsp_layer_id, rsp_raw_value,
                rsp_point_x, rsp_point_y, rsp_box_lo_x, rsp_box_lo_y,
                rsp_box_hi_x, rsp_box_hi_y, rsp_point_total, rsp_code};
         if (expected_events.size() == 0) begin
            $error("unexpected result transfer kind=%0d", got.event_kind);
            error_count++;
         end else begin
            want = expected_events.pop_front();
            if (got.event_kind != want.event_kind) begin
               $error("event_kind exp %0d got %0d", want.event_kind, got.event_kind);
               error_count++;
            end
            if (got.last_of_run != want.last_of_run) begin
               $error("last_of_run exp %0d got %0d", want.last_of_run, got.last_of_run);
               error_count++;
            end
            if (got.layer_id != want.layer_id) begin
               $error("layer_id exp %0d got %0d", want.layer_id, got.layer_id);
               error_count++;
            end
            if (got.raw_value != want.raw_value) begin
               $error("raw_value exp %h got %h", want.raw_value, got.raw_value);
               error_count++;
            end
            if (got.point_x != want.point_x) begin
               $error("point_x exp %0d got %0d", want.point_x, got.point_x);
               error_count++;
            end
            if (got.point_y != want.point_y) begin
               $error("point_y exp %0d got %0d", want.point_y, got.point_y);
               error_count++;
            end
            if (got.box_lo_x != want.box_lo_x) begin
               $error("box_lo_x exp %0d got %0d", want.box_lo_x, got.box_lo_x);
               error_count++;
            end
            if (got.box_lo_y != want.box_lo_y) begin
               $error("box_lo_y exp %0d got %0d", want.box_lo_y, got.box_lo_y);
               error_count++;
            end
            if (got.box_hi_x != want.box_hi_x) begin
               $error("box_hi_x exp %0d got %0d", want.box_hi_x, got.box_hi_x);
               error_count++;
            end
            if (got.box_hi_y != want.box_hi_y) begin
               $error("box_hi_y exp %0d got %0d", want.box_hi_y, got.box_hi_y);
               error_count++;
            end
            if (got.point_total != want.point_total) begin
               $error("point_total exp %0d got %0d", want.point_total, got.point_total);
               error_count++;
            end
            if (got.code != want.code) begin
               $error("code exp %0d got %0d", want.code, got.code);
               error_count++;
            end
         end
      end
   end

   // Timeout watchdog
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int total;
      byte_item_t it;
      reset = 1'b1; req_valid = 1'b0; req_in_byte = 8'h00; req_last_byte = 1'b0;
      rsp_stall = 1'b0; error_count = 0; cycle_count = 0;
      send_idle_pct = 29; recv_idle_pct = 45;
      parse_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: short file, bad magic, bad version, minimal ok, truncated
      file_bytes = {}; put_bytes(64'h4D52, 2); queue_file();
      file_bytes = {}; put_bytes(64'h00FF_4D52, 4); queue_file();
      file_bytes = {}; put_bytes(64'h0002_5041_4D52, 6); queue_file();
      // zero layers, then trailing junk after completion
      file_bytes = {}; put_bytes(64'h0000_0001_5041_4D52, 8);
      put_bytes(64'h0, 8); put_bytes(64'hFFFF_FFFF_FFFF_FFFF, 8);
      put_bytes(64'h8000_0000_0000_0001, 8); put_bytes(64'h7FFF_FFFF_FFFF_FFFE, 8);
      put_bytes(64'h0, 2); put_bytes(64'hAA55, 2); queue_file();
      // two layers: empty polyline, one-point, two-point polylines with extremes, then an empty layer
      file_bytes = {}; put_bytes(64'h0000_0001_5041_4D52, 8);
      for (int i = 0; i < 4; i++) put_bytes(rand64(), 8);
      put_bytes(64'h2, 2);
      put_bytes({32'd3, 16'hFFFF, 8'h00, 8'hFF}, 8);
      put_bytes(64'h0, 2);
      put_bytes(64'h1, 2); put_bytes(64'hFFFF, 2); put_bytes(64'h0000, 2);
      put_bytes(64'h2, 2); put_bytes(64'h0000, 2); put_bytes(64'hFFFF, 2);
      put_bytes(64'hFFFF, 2); put_bytes(64'h0000, 2);
      put_bytes({32'd0, 16'h0, 8'hA5, 8'h00}, 8);
      queue_file();
      // truncated mid-structure
      build_file(2, 2, 3);
      void'(file_bytes.pop_back()); queue_file();
      wait_drained();

      // Random: mostly well-formed files, some cut short or corrupted
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 45 : 0;
         recv_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 29 : 0;
         total = 0;
         while (total < 80) begin
            build_file(3, 3, 4);
            case ($urandom_range(0, 9))
               0: file_bytes = file_bytes[0:$urandom_range(0, file_bytes.size() - 1)];
               1: file_bytes[$urandom_range(0, 4)].data = 8'($urandom_range(0, 255));
               2: begin
                  it.data = 8'($urandom_range(0, 255)); it.fin = 1'b0;
                  file_bytes = {file_bytes, it};
               end
               default: ;
            endcase
            total += file_bytes.size();
            queue_file();
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_events.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
